[rtl/psc_pkg.sv]
// Shared types and codes for the postfix stack calculator.
// Used by psc_alu, postfix_stack_calculator_top and psc_checker; no dependencies.
package psc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DEPTH_W  = 7;
    localparam int unsigned DIV_CNT_W = 5;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_POP  = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_BADOP = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_FETCH,
        C_ALU
    } ctrl_state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX
    } alu_state_t;

    typedef struct packed {
        logic                start;
        opcode_t             op;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic                done;
        logic [WORD_W-1:0]   result;
    } alu_rsp_t;

endpackage

[rtl/psc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/psc_alu.sv]
// Shared arithmetic unit: add, subtract, multiply and a radix-2 restoring divider
// that reuses the one 33-bit adder. Depends on psc_pkg.
module psc_alu
    import psc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    alu_state_t           state_reg, state_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [WORD_W-1:0]    res_reg, res_next;
    logic                 done_reg, done_next;

    logic [WORD_W-1:0]    add_x, add_y;
    logic                 add_sub;
    logic [WORD_W:0]      sum;
    logic [2*WORD_W-1:0]  prod;
    logic [WORD_W-1:0]    mag_a, mag_b;

    always_comb begin
        if (state_reg == A_DIV) begin
            add_x   = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
            add_y   = dvs_reg;
            add_sub = 1'b1;
        end else begin
            add_x   = req.a;
            add_y   = req.b;
            add_sub = (req.op == OP_SUB);
        end
        sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (WORD_W+1)'(add_sub);
    end

    assign prod  = (2*WORD_W)'(req.a) * (2*WORD_W)'(req.b);
    assign mag_a = req.a[WORD_W-1] ? (~req.a + 1'b1) : req.a;
    assign mag_b = req.b[WORD_W-1] ? (~req.b + 1'b1) : req.b;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start && (req.op == OP_DIV)) begin
                    state_next = A_DIV;
                end
            end
            A_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = A_FIX;
                end
            end
            A_FIX: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    case (req.op) inside
                        OP_ADD, OP_SUB: begin
                            res_next  = sum[WORD_W-1:0];
                            done_next = 1'b1;
                        end
                        OP_MUL: begin
                            res_next  = prod[WORD_W-1:0];
                            done_next = 1'b1;
                        end
                        OP_DIV: begin
                            quo_next = mag_a;
                            rem_next = '0;
                            dvs_next = mag_b;
                            cnt_next = '1;
                            neg_next = req.a[WORD_W-1] ^ req.b[WORD_W-1];
                        end
                        default: begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            A_DIV: begin
                quo_next = {quo_reg[WORD_W-2:0], sum[WORD_W]};
                rem_next = sum[WORD_W] ? sum[WORD_W-1:0] : add_x;
                cnt_next = cnt_reg - 1'b1;
            end
            A_FIX: begin
                res_next  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                done_next = 1'b1;
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

[rtl/postfix_stack_calculator_top.sv]
// Postfix stack calculator: top of stack in a register, the rest in psc_ram,
// arithmetic in psc_alu. Depends on psc_pkg, psc_ram and psc_alu.
//
//   channel  dir  tdata                          tuser
//   s_       in   [31:0] operand                 [2:0] opcode
//   m_       out  [31:0] value, [38:32] depth    [2:0] status
//
// Push, errors and every pop register their result beat on acceptance; a pop from a
// deeper stack then reads the new top from RAM; add, sub and mul read the RAM and then
// use the ALU; div runs the 32 steps of the divider on the shared adder plus sign fix.
// Reset clears the entry count, the control state and the result valid; the RAM holds no reset state.
// s_tready is low while an item is in progress or a result beat is stalled.
module postfix_stack_calculator_top
    import psc_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value, [38:32] depth, [39] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

    ctrl_state_t       state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [WORD_W-1:0] top_reg, top_next;
    opcode_t           op_reg, op_next;
    logic              pop_reg, pop_next;

    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_value_reg;
    logic [DEPTH_W-1:0] m_depth_reg;
    status_t           m_status_reg;

    logic              accept, fetch, out_load;
    logic [WORD_W-1:0] out_value, top_or_zero;
    logic [SP_W-1:0]   out_depth;
    status_t           out_status;
    opcode_t           in_op;

    logic [SP_W-1:0]   sp_inc, sp_dec, sp_dec2;
    logic              wr_en, rd_en;
    logic [WORD_W-1:0] wr_data, rd_data;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    assign s_tready    = (state_reg == C_IDLE) && (!m_valid_reg || m_tready);
    assign accept      = s_tvalid && s_tready;
    assign in_op       = opcode_t'(s_tuser);
    assign sp_inc      = sp_reg + 1'b1;
    assign sp_dec      = sp_reg - 1'b1;
    assign sp_dec2     = sp_reg - SP_W'(2);
    assign top_or_zero = (sp_reg == '0) ? '0 : top_reg;
    assign wr_data     = top_reg;

    psc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (sp_dec[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (sp_dec2[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    psc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    always_comb begin
        sp_next       = sp_reg;
        top_next      = top_reg;
        op_next       = op_reg;
        pop_next      = pop_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        fetch         = 1'b0;
        out_load      = 1'b0;
        out_value     = top_or_zero;
        out_depth     = sp_reg;
        out_status    = ST_OK;
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;
        alu_req.a     = rd_data;
        alu_req.b     = top_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    case (in_op) inside
                        OP_PUSH: begin
                            if (sp_reg == SP_W'(STACK_DEPTH)) begin
                                out_status = ST_OVER;
                            end else begin
                                wr_en     = (sp_reg != '0);
                                top_next  = s_tdata;
                                sp_next   = sp_inc;
                                out_value = s_tdata;
                                out_depth = sp_inc;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (sp_reg < SP_W'(2)) begin
                                out_status = ST_UNDER;
                            end else if ((in_op == OP_DIV) && (top_reg == '0)) begin
                                out_status = ST_DIVZ;
                            end else begin
                                out_load = 1'b0;
                                rd_en    = 1'b1;
                                fetch    = 1'b1;
                                op_next  = in_op;
                                pop_next = 1'b0;
                            end
                        end
                        OP_POP: begin
                            if (sp_reg == '0) begin
                                out_status = ST_UNDER;
                                out_value  = '0;
                            end else begin
                                out_value = top_reg;
                                out_depth = sp_dec;
                                sp_next   = sp_dec;
                                if (sp_reg >= SP_W'(2)) begin
                                    rd_en    = 1'b1;
                                    fetch    = 1'b1;
                                    pop_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            out_status = ST_BADOP;
                        end
                    endcase
                end
            end
            C_FETCH: begin
                if (pop_reg) begin
                    top_next = rd_data;
                end else begin
                    alu_req.start = 1'b1;
                end
            end
            C_ALU: begin
                if (alu_rsp.done) begin
                    top_next  = alu_rsp.result;
                    sp_next   = sp_dec;
                    out_load  = 1'b1;
                    out_value = alu_rsp.result;
                    out_depth = sp_dec;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (fetch) begin
                    state_next = C_FETCH;
                end
            end
            C_FETCH: begin
                state_next = pop_reg ? C_IDLE : C_ALU;
            end
            C_ALU: begin
                if (alu_rsp.done) begin
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg <= top_next;
        op_reg  <= op_next;
        pop_reg <= pop_next;
        if (out_load) begin
            m_value_reg  <= out_value;
            m_depth_reg  <= DEPTH_W'(out_depth);
            m_status_reg <= out_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_depth_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

endmodule

[rtl/psc_checker.sv]
// Port-level assertions for postfix_stack_calculator_top, attached by bind.
// Depends on psc_pkg.
module psc_checker
    import psc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("input beat taken while result beat stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= 3'(ST_BADOP)))
        else $error("result status out of range");

    a_empty_under: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == 3'(ST_UNDER)) && (m_tdata[38:32] == '0))
            |-> (m_tdata[31:0] == '0))
        else $error("underflow on empty stack with non-zero value");

endmodule

bind postfix_stack_calculator_top psc_checker u_psc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
